>>> design/bmw_pkg.sv
// Package of constants, types and helper functions for the binary morphology window.
`default_nettype none
package bmw_pkg;

  // Frame and element limits.
  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int MAX_RADIUS = 4;

  // Column vector height and window width.
  localparam int VEC_W  = 2 * MAX_RADIUS + 1;
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int COLS_W = $clog2(MAX_COLS + 1);
  localparam int CW1    = COLS_W + 1;
  localparam int ROWS_W = $clog2(MAX_ROWS + 1);
  // Positions keep running past the last row while the latency drains.
  localparam int ROW_W  = $clog2(MAX_ROWS + 4 * MAX_RADIUS + 2);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int LAT_W  = RAD_W + COLS_W + 1;
  localparam int SEQ_W  = $clog2(MAX_ROWS * MAX_COLS + 4 * (MAX_RADIUS * MAX_COLS + MAX_RADIUS) + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_SHAPE  = 3'd1,
    CFG_RADIUS = 3'd2,
    CFG_COLS   = 3'd3,
    CFG_ROWS   = 3'd4
  } cfg_idx_t;

  localparam logic [1:0] MODE_DILATE = 2'd0;
  localparam logic [1:0] MODE_ERODE  = 2'd1;
  localparam logic [1:0] MODE_CLOSE  = 2'd2;

  // Result queue; the depth is a power of two so the pointers wrap naturally.
  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef logic [VEC_W-1:0]            vec_t;
  typedef logic [VEC_W-1:0][VEC_W-1:0] win_t;

  // Control that travels with one item down the pipeline.
  typedef struct packed {
    logic              pix;
    logic [COL_W-1:0]  p_col;
    logic              push2;
    logic [ROW_W-1:0]  c1_row;
    logic [COL_W-1:0]  c1_col;
    logic [ROW_W-1:0]  c2_row;
    logic [COL_W-1:0]  c2_col;
    logic [ROWS_W-1:0] rows;
    logic [COLS_W-1:0] cols;
    logic [RAD_W-1:0]  radius;
    logic              shape;
    logic              shrink1;
    logic              closing;
    logic              have;
    logic              last;
  } item_ctl_t;

  function automatic logic [COLS_W-1:0] clamp_cols(logic [CFG_DATA_W-1:0] v);
    if (v == '0) return COLS_W'(1);
    if (int'(v) > MAX_COLS) return COLS_W'(MAX_COLS);
    return COLS_W'(v);
  endfunction

  function automatic logic [ROWS_W-1:0] clamp_rows(logic [CFG_DATA_W-1:0] v);
    if (v == '0) return ROWS_W'(1);
    if (int'(v) > MAX_ROWS) return ROWS_W'(MAX_ROWS);
    return ROWS_W'(v);
  endfunction

  function automatic logic [RAD_W-1:0] clamp_radius(logic [2:0] v);
    if (int'(v) > MAX_RADIUS) return RAD_W'(MAX_RADIUS);
    return RAD_W'(v);
  endfunction

  // True when a column index is the last of its row.
  function automatic logic col_wraps(logic [COL_W-1:0] col, logic [COLS_W-1:0] cols);
    return (CW1'(col) + CW1'(1)) >= CW1'(cols);
  endfunction

  // Decide one pixel from its window. Entry k of the window is the column at
  // dx = radius - k, bit j of a column is the row at dy = radius - j.
  function automatic logic probe(win_t w, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                 logic [ROWS_W-1:0] rows, logic [COLS_W-1:0] cols,
                                 logic [RAD_W-1:0] rad, logic shape, logic shrink);
    int   ri;
    int   dy;
    int   dx;
    int   y;
    int   x;
    logic hit;
    hit = 1'b0;
    ri  = int'(rad);
    for (int k = 0; k < VEC_W; k++) begin
      for (int j = 0; j < VEC_W; j++) begin
        dy = ri - j;
        dx = ri - k;
        y  = int'(row) + dy;
        x  = int'(col) + dx;
        if (j <= 2 * ri && k <= 2 * ri && (shape || dy * dy + dx * dx <= ri * ri) &&
            y >= 0 && y < int'(rows) && x >= 0 && x < int'(cols)) begin
          if (shrink ? !w[k][j] : w[k][j]) hit = 1'b1;
        end
      end
    end
    return shrink ? !hit : hit;
  endfunction

endpackage
`default_nettype wire

>>> design/bmw_ifs.sv
// Channel interfaces for pixels in, results out and configuration writes.
`default_nettype none
interface bmw_pix_in_if;
  logic valid;
  logic ready;
  logic pixel_in;
  logic is_flush;
  modport source (output valid, output pixel_in, output is_flush, input ready);
  modport sink   (input valid, input pixel_in, input is_flush, output ready);
endinterface

interface bmw_pix_out_if;
  logic valid;
  logic ready;
  logic pixel_out;
  logic frame_last;
  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface bmw_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [10:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> design/binary_morphology_window.sv
// Throughput: one item per cycle while the result queue has room for all items in
// flight. The pixel at raster position p leaves with item p + L (dilation, erosion)
// or p + 2L (closing), L = radius*cols + radius; results pass stages b-e to the queue.
// The line memories are one column vector per column, read and written once a cycle.
// Reset clears control and configuration; memories are not cleared, as rows not yet
// written in the current frame are always masked out of the window.
`default_nettype none
module binary_morphology_window (
  input  wire logic    clk,
  input  wire logic    rst_n,
  bmw_pix_in_if.sink   in_ch,
  bmw_pix_out_if.source out_ch,
  bmw_cfg_if.sink      cfg_ch
);
  import bmw_pkg::*;

  // Configuration registers and the copy latched for the running frame.
  logic [1:0]            mode_r, mode_nxt;
  logic                  shape_r, shape_nxt;
  logic [2:0]            radius_r, radius_nxt;
  logic [CFG_DATA_W-1:0] cols_r, cols_nxt;
  logic [CFG_DATA_W-1:0] rows_r, rows_nxt;
  logic [1:0]            cur_mode_r;
  logic                  cur_shape_r;
  logic [RAD_W-1:0]      cur_radius_r;
  logic [COLS_W-1:0]     cur_cols_r;
  logic [ROWS_W-1:0]     cur_rows_r;

  // Frame position counters.
  logic [SEQ_W-1:0] seq_r, seq_nxt;
  logic [ROW_W-1:0] p_row_r, p_row_nxt, c1_row_r, c1_row_nxt, c2_row_r, c2_row_nxt;
  logic [COL_W-1:0] p_col_r, p_col_nxt, c1_col_r, c1_col_nxt, c2_col_r, c2_col_nxt;

  // Effective settings for the item at the input.
  logic [1:0]        eff_mode;
  logic              eff_shape;
  logic [RAD_W-1:0]  eff_radius;
  logic [COLS_W-1:0] eff_cols;
  logic [ROWS_W-1:0] eff_rows;
  logic [LAT_W-1:0]  lat;
  logic [LAT_W:0]    lat2;
  logic              closing, act1, act2, have1, have2, last1, last2;
  logic              accept, cfg_accept;
  item_ctl_t         a_ctl;

  // Pipeline stages.
  logic      vb_r, vc_r, vd_r, ve_r;
  item_ctl_t b_r, c_r, d_r, e_r;
  logic      fwd1_r, fwd2_r;
  logic      res1_c, res1_d_r, res1_e_r, res2_e;

  // Line memories, their read data and the windows.
  vec_t mem1 [MAX_COLS];
  vec_t mem2 [MAX_COLS];
  vec_t rd1_r, rd2_r, last1_r, last2_r, base1, base2, vec1, vec2;
  win_t win1_r, win2_r;

  // Result queue.
  logic                 q_pix [OUT_DEPTH];
  logic                 q_last [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OUT_CNT_W-1:0] cnt_r;
  logic [OUT_CNT_W:0]   occ;
  logic                 q_push, q_pop, out_bit;

  assign accept     = in_ch.valid && in_ch.ready;
  assign cfg_accept = cfg_ch.valid && cfg_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Configuration writes.
  always_comb begin
    mode_nxt   = mode_r;
    shape_nxt  = shape_r;
    radius_nxt = radius_r;
    cols_nxt   = cols_r;
    rows_nxt   = rows_r;
    if (cfg_accept) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_MODE:   mode_nxt   = cfg_ch.data[1:0];
        CFG_SHAPE:  shape_nxt  = cfg_ch.data[0];
        CFG_RADIUS: radius_nxt = cfg_ch.data[2:0];
        CFG_COLS:   cols_nxt   = cfg_ch.data;
        CFG_ROWS:   rows_nxt   = cfg_ch.data;
        default:    mode_nxt   = mode_r;
      endcase
    end
  end

  // Settings for this item: latched from the registers on the first item of a frame.
  always_comb begin
    if (seq_r == '0) begin
      eff_mode   = mode_r;
      eff_shape  = shape_r;
      eff_radius = clamp_radius(radius_r);
      eff_cols   = clamp_cols(cols_r);
      eff_rows   = clamp_rows(rows_r);
    end else begin
      eff_mode   = cur_mode_r;
      eff_shape  = cur_shape_r;
      eff_radius = cur_radius_r;
      eff_cols   = cur_cols_r;
      eff_rows   = cur_rows_r;
    end
  end

  // Latency compares and result decision for the item at the input.
  always_comb begin
    closing = eff_mode[1];
    lat     = LAT_W'(eff_radius) * LAT_W'(eff_cols) + LAT_W'(eff_radius);
    lat2    = {lat, 1'b0};
    act1    = seq_r >= SEQ_W'(lat);
    act2    = closing && (seq_r >= SEQ_W'(lat2));
    have1   = act1 && !closing && (c1_row_r < ROW_W'(eff_rows));
    have2   = act2 && (c2_row_r < ROW_W'(eff_rows));
    last1   = (c1_row_r == ROW_W'(eff_rows) - ROW_W'(1)) &&
              (CW1'(c1_col_r) == CW1'(eff_cols) - CW1'(1));
    last2   = (c2_row_r == ROW_W'(eff_rows) - ROW_W'(1)) &&
              (CW1'(c2_col_r) == CW1'(eff_cols) - CW1'(1));

    a_ctl.pix     = in_ch.pixel_in;
    a_ctl.p_col   = p_col_r;
    a_ctl.push2   = closing && act1;
    a_ctl.c1_row  = c1_row_r;
    a_ctl.c1_col  = c1_col_r;
    a_ctl.c2_row  = c2_row_r;
    a_ctl.c2_col  = c2_col_r;
    a_ctl.rows    = eff_rows;
    a_ctl.cols    = eff_cols;
    a_ctl.radius  = eff_radius;
    a_ctl.shape   = eff_shape;
    a_ctl.shrink1 = !closing && (eff_mode == MODE_ERODE);
    a_ctl.closing = closing;
    a_ctl.have    = have1 || have2;
    a_ctl.last    = have1 ? last1 : (have2 && last2);
  end

  // Input position advances on every transfer, result positions once active; all restart after the frame's last result.
  always_comb begin
    seq_nxt    = seq_r;
    p_row_nxt  = p_row_r;
    p_col_nxt  = p_col_r;
    c1_row_nxt = c1_row_r;
    c1_col_nxt = c1_col_r;
    c2_row_nxt = c2_row_r;
    c2_col_nxt = c2_col_r;
    if (accept) begin
      if (a_ctl.have && a_ctl.last) begin
        seq_nxt    = '0;
        p_row_nxt  = '0;
        p_col_nxt  = '0;
        c1_row_nxt = '0;
        c1_col_nxt = '0;
        c2_row_nxt = '0;
        c2_col_nxt = '0;
      end else begin
        seq_nxt = seq_r + SEQ_W'(1);
        if (col_wraps(p_col_r, eff_cols)) begin
          p_col_nxt = '0;
          p_row_nxt = p_row_r + ROW_W'(1);
        end else begin
          p_col_nxt = p_col_r + COL_W'(1);
        end
        if (act1) begin
          if (col_wraps(c1_col_r, eff_cols)) begin
            c1_col_nxt = '0;
            c1_row_nxt = c1_row_r + ROW_W'(1);
          end else begin
            c1_col_nxt = c1_col_r + COL_W'(1);
          end
        end
        if (act2) begin
          if (col_wraps(c2_col_r, eff_cols)) begin
            c2_col_nxt = '0;
            c2_row_nxt = c2_row_r + ROW_W'(1);
          end else begin
            c2_col_nxt = c2_col_r + COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_DILATE;
      shape_r      <= 1'b0;
      radius_r     <= 3'd1;
      cols_r       <= CFG_DATA_W'(1024);
      rows_r       <= CFG_DATA_W'(1024);
      cur_mode_r   <= MODE_DILATE;
      cur_shape_r  <= 1'b0;
      cur_radius_r <= RAD_W'(1);
      cur_cols_r   <= COLS_W'(1);
      cur_rows_r   <= ROWS_W'(1);
      seq_r        <= '0;
      p_row_r      <= '0;
      p_col_r      <= '0;
      c1_row_r     <= '0;
      c1_col_r     <= '0;
      c2_row_r     <= '0;
      c2_col_r     <= '0;
    end else begin
      mode_r   <= mode_nxt;
      shape_r  <= shape_nxt;
      radius_r <= radius_nxt;
      cols_r   <= cols_nxt;
      rows_r   <= rows_nxt;
      if (accept) begin
        cur_mode_r   <= eff_mode;
        cur_shape_r  <= eff_shape;
        cur_radius_r <= eff_radius;
        cur_cols_r   <= eff_cols;
        cur_rows_r   <= eff_rows;
      end
      seq_r    <= seq_nxt;
      p_row_r  <= p_row_nxt;
      p_col_r  <= p_col_nxt;
      c1_row_r <= c1_row_nxt;
      c1_col_r <= c1_col_nxt;
      c2_row_r <= c2_row_nxt;
      c2_col_r <= c2_col_nxt;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      vb_r <= accept;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  // Stage one: read the column vector, shift in the new pixel, write it back.
  // The forward flag covers a write to the same column in the cycle of the read.
  assign base1 = fwd1_r ? last1_r : rd1_r;
  assign vec1  = {base1[VEC_W-2:0], b_r.pix};

  always_ff @(posedge clk) begin
    if (accept) begin
      rd1_r  <= mem1[p_col_r];
      fwd1_r <= vb_r && (b_r.p_col == p_col_r);
      b_r    <= a_ctl;
    end
    if (vb_r) begin
      mem1[b_r.p_col] <= vec1;
      last1_r         <= vec1;
      win1_r          <= {win1_r[VEC_W-2:0], vec1};
    end
  end

  // Stage one decision from its window.
  assign res1_c = probe(win1_r, c_r.c1_row, c_r.c1_col, c_r.rows, c_r.cols,
                        c_r.radius, c_r.shape, c_r.shrink1);

  // Stage two line memory takes the stage one results when closing.
  assign base2 = fwd2_r ? last2_r : rd2_r;
  assign vec2  = {base2[VEC_W-2:0], res1_d_r};

  always_ff @(posedge clk) begin
    if (vb_r) begin
      c_r <= b_r;
    end
    if (vc_r) begin
      d_r      <= c_r;
      res1_d_r <= res1_c;
      fwd2_r   <= vd_r && d_r.push2 && (d_r.c1_col == c_r.c1_col);
      if (c_r.push2) begin
        rd2_r <= mem2[c_r.c1_col];
      end
    end
    if (vd_r) begin
      e_r      <= d_r;
      res1_e_r <= res1_d_r;
      if (d_r.push2) begin
        mem2[d_r.c1_col] <= vec2;
        last2_r          <= vec2;
        win2_r           <= {win2_r[VEC_W-2:0], vec2};
      end
    end
  end

  // Stage two erosion and the result choice.
  assign res2_e  = probe(win2_r, e_r.c2_row, e_r.c2_col, e_r.rows, e_r.cols,
                         e_r.radius, e_r.shape, 1'b1);
  assign out_bit = e_r.closing ? res2_e : res1_e_r;

  // Result queue; input is held off unless every item in flight has a slot.
  assign q_push = ve_r && e_r.have;
  assign q_pop  = out_ch.valid && out_ch.ready;
  assign occ    = (OUT_CNT_W+1)'(cnt_r) + (OUT_CNT_W+1)'(vb_r) + (OUT_CNT_W+1)'(vc_r) +
                  (OUT_CNT_W+1)'(vd_r) + (OUT_CNT_W+1)'(ve_r);
  assign in_ch.ready       = occ < (OUT_CNT_W+1)'(OUT_DEPTH);
  assign out_ch.valid      = cnt_r != '0;
  assign out_ch.pixel_out  = q_pix[rd_ptr_r];
  assign out_ch.frame_last = q_last[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_pix[wr_ptr_r]  <= out_bit;
      q_last[wr_ptr_r] <= e_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_push) wr_ptr_r <= wr_ptr_r + OUT_PTR_W'(1);
      if (q_pop) rd_ptr_r <= rd_ptr_r + OUT_PTR_W'(1);
      cnt_r <= cnt_r + OUT_CNT_W'(q_push) - OUT_CNT_W'(q_pop);
    end
  end

endmodule
`default_nettype wire
